// File: hw/rtl/alarm_slot_table_scheduler_macros.svh
// alarm_slot_table_scheduler_macros.svh: assertion macros for the alarm slot table
// needs clk_i and rst_ni in the scope where a macro is used
`ifndef ALARM_SLOT_TABLE_SCHEDULER_MACROS_SVH
`define ALARM_SLOT_TABLE_SCHEDULER_MACROS_SVH

// property checked on every clock edge outside reset
`define AST_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("alarm slot table: property failed");

// condition that must never be seen outside reset
`define AST_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("alarm slot table: forbidden condition seen");

`endif

// File: hw/rtl/ast_pkg.sv
// ast_pkg: types and constants of the alarm slot table scheduler
// no dependencies; used by every rtl file of the block but ast_fifo
`default_nettype none

package ast_pkg;

  // alarm word layout
  localparam int unsigned ID_W         = 8;
  localparam int unsigned ID_LSB       = 24;
  localparam int unsigned PERIODIC_BIT = 23;
  localparam int unsigned DELAY_W      = 23;
  localparam int unsigned TIME_W       = 32;
  // delay threshold in microseconds, delay_ms * 1000 needs 33 bits
  localparam int unsigned THR_W        = 33;
  localparam int unsigned US_PER_MS    = 1000;

  typedef enum logic {
    MODE_SET   = 1'b0,
    MODE_CHECK = 1'b1
  } mode_e;

  // request as it arrives at the input port
  typedef struct packed {
    mode_e              mode;
    logic [31:0]        alarm_word;
    logic [TIME_W-1:0]  now_us;
  } in_item_t;

  // one fired alarm
  typedef struct packed {
    logic [ID_W-1:0] fired_event_id;
    logic            last_fired;
  } out_item_t;

  // decoded request handed from the front end to the back end
  typedef struct packed {
    mode_e             mode;
    logic [ID_W-1:0]   id;
    logic              periodic;
    logic              enable;
    logic [THR_W-1:0]  thr_us;
    logic [TIME_W-1:0] now_us;
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_FLUSH
  } state_e;

endpackage

`default_nettype wire

// File: hw/rtl/ast_fifo.sv
// ast_fifo: small first-in first-out queue of register entries
// generic over the entry type; used by the front and the back end
`default_nettype none

module ast_fifo #(
  parameter int  Depth = 2,
  parameter type T     = logic
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire T     wdata_i,
  output logic      full_o,
  input  wire logic pop_i,
  output T          rdata_o,
  output logic      empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  T                mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/ast_front.sv
// ast_front: accepts requests, decodes the alarm word and queues commands
// depends on ast_pkg and ast_fifo
`default_nettype none

module ast_front (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire ast_pkg::in_item_t in_item_i,
  output logic            cmd_valid_o,
  input  wire logic       cmd_pop_i,
  output ast_pkg::cmd_t   cmd_o
);

  ast_pkg::cmd_t              dec;
  logic [ast_pkg::DELAY_W-1:0] delay_ms;
  logic                       cmd_empty;

  // split the alarm word and turn the delay into a microsecond threshold
  always_comb begin
    delay_ms     = in_item_i.alarm_word[ast_pkg::DELAY_W-1:0];
    dec.mode     = in_item_i.mode;
    dec.id       = in_item_i.alarm_word[ast_pkg::ID_LSB +: ast_pkg::ID_W];
    dec.periodic = in_item_i.alarm_word[ast_pkg::PERIODIC_BIT];
    dec.enable   = (delay_ms != '0);
    dec.thr_us   = ast_pkg::THR_W'(delay_ms) * ast_pkg::THR_W'(ast_pkg::US_PER_MS);
    dec.now_us   = in_item_i.now_us;
  end

  // command queue towards the slot walker
  ast_fifo #(
    .Depth (2),
    .T     (ast_pkg::cmd_t)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (dec),
    .full_o  (full),
    .pop_i   (cmd_pop_i),
    .rdata_o (cmd_o),
    .empty_o (cmd_empty)
  );

  assign cmd_valid_o = !cmd_empty;

endmodule

`default_nettype wire

// File: hw/rtl/ast_back.sv
// ast_back: slot table and walker that carries out set and check commands
// depends on ast_pkg, ast_fifo and the assertion macros header
`default_nettype none
`include "alarm_slot_table_scheduler_macros.svh"

module ast_back #(
  parameter int SlotCount = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  input  wire ast_pkg::cmd_t cmd_i,
  output logic               cmd_pop_o,
  output logic               empty,
  input  wire logic          pop,
  output ast_pkg::out_item_t out_item_o
);

  localparam int IdxW = (SlotCount > 1) ? $clog2(SlotCount) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SlotCount - 1);

  // slot table
  logic [SlotCount-1:0]       active_q;
  logic [ast_pkg::ID_W-1:0]   id_q    [SlotCount];
  logic                       per_q   [SlotCount];
  logic [ast_pkg::THR_W-1:0]  thr_q   [SlotCount];
  logic [ast_pkg::TIME_W-1:0] start_q [SlotCount];

  ast_pkg::state_e           state_q, state_d;
  logic [IdxW-1:0]           idx_q, idx_d;
  logic                      match_v_q, match_v_d;
  logic [IdxW-1:0]           match_idx_q, match_idx_d;
  logic                      free_v_q, free_v_d;
  logic [IdxW-1:0]           free_idx_q, free_idx_d;
  logic                      pend_v_q, pend_v_d;
  logic [ast_pkg::ID_W-1:0]  pend_id_q, pend_id_d;

  logic                       is_check;
  logic [ast_pkg::TIME_W-1:0] elapsed;
  logic                       cur_hit, cur_fire, scan_last, stall;
  logic                       fire_upd, commit_wr;
  logic [IdxW-1:0]            tgt_idx;
  logic                       out_push, out_full;
  ast_pkg::out_item_t         out_data;

  // look at the slot under the cursor
  assign is_check  = (cmd_i.mode == ast_pkg::MODE_CHECK);
  assign elapsed   = cmd_i.now_us - start_q[idx_q];
  assign cur_hit   = active_q[idx_q] && (id_q[idx_q] == cmd_i.id);
  assign cur_fire  = active_q[idx_q] && ({1'b0, elapsed} >= thr_q[idx_q]);
  assign scan_last = (idx_q == LastIdx);
  assign stall     = is_check && cur_fire && pend_v_q && out_full;
  assign tgt_idx   = match_v_q ? match_idx_q : free_idx_q;

  // walker: next state and outputs
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    match_v_d   = match_v_q;
    match_idx_d = match_idx_q;
    free_v_d    = free_v_q;
    free_idx_d  = free_idx_q;
    pend_v_d    = pend_v_q;
    pend_id_d   = pend_id_q;
    cmd_pop_o   = 1'b0;
    out_push    = 1'b0;
    out_data    = '{fired_event_id: pend_id_q, last_fired: 1'b0};
    fire_upd    = 1'b0;
    commit_wr   = 1'b0;
    case (state_q)
      ast_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          state_d   = ast_pkg::ST_SCAN;
          idx_d     = '0;
          match_v_d = 1'b0;
          free_v_d  = 1'b0;
          pend_v_d  = 1'b0;
        end
      end
      ast_pkg::ST_SCAN: begin
        if (!is_check) begin
          // set: remember the first slot with this id and the first free slot
          if (cur_hit && !match_v_q) begin
            match_v_d   = 1'b1;
            match_idx_d = idx_q;
          end
          if (!active_q[idx_q] && !free_v_q) begin
            free_v_d   = 1'b1;
            free_idx_d = idx_q;
          end
          if (scan_last) begin
            state_d = ast_pkg::ST_COMMIT;
          end else begin
            idx_d = idx_q + IdxW'(1);
          end
        end else if (!stall) begin
          // check: hold one fired id back so the last one can be marked
          if (cur_fire) begin
            fire_upd  = 1'b1;
            out_push  = pend_v_q;
            pend_v_d  = 1'b1;
            pend_id_d = id_q[idx_q];
          end
          if (scan_last) begin
            state_d = ast_pkg::ST_FLUSH;
          end else begin
            idx_d = idx_q + IdxW'(1);
          end
        end
      end
      ast_pkg::ST_COMMIT: begin
        commit_wr = match_v_q || free_v_q;
        cmd_pop_o = 1'b1;
        state_d   = ast_pkg::ST_IDLE;
      end
      ast_pkg::ST_FLUSH: begin
        if (!pend_v_q || !out_full) begin
          out_push            = pend_v_q;
          out_data.last_fired = 1'b1;
          pend_v_d            = 1'b0;
          cmd_pop_o           = 1'b1;
          state_d             = ast_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ast_pkg::ST_IDLE;
      end
    endcase
  end

  // walker control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ast_pkg::ST_IDLE;
      idx_q     <= '0;
      match_v_q <= 1'b0;
      free_v_q  <= 1'b0;
      pend_v_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      match_v_q <= match_v_d;
      free_v_q  <= free_v_d;
      pend_v_q  <= pend_v_d;
    end
  end

  // walker payload registers
  always_ff @(posedge clk_i) begin
    match_idx_q <= match_idx_d;
    free_idx_q  <= free_idx_d;
    pend_id_q   <= pend_id_d;
  end

  // active flags: cleared by reset, freed by a one-shot fire, written by a commit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (commit_wr) begin
      active_q[tgt_idx] <= cmd_i.enable;
    end else if (fire_upd && !per_q[idx_q]) begin
      active_q[idx_q] <= 1'b0;
    end
  end

  // slot contents: loaded by a commit, restarted by a periodic fire
  always_ff @(posedge clk_i) begin
    if (commit_wr) begin
      id_q[tgt_idx]    <= cmd_i.id;
      per_q[tgt_idx]   <= cmd_i.periodic;
      thr_q[tgt_idx]   <= cmd_i.thr_us;
      start_q[tgt_idx] <= cmd_i.now_us;
    end else if (fire_upd && per_q[idx_q]) begin
      start_q[idx_q] <= cmd_i.now_us;
    end
  end

  // result queue
  ast_fifo #(
    .Depth (2),
    .T     (ast_pkg::out_item_t)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .wdata_i (out_data),
    .full_o  (out_full),
    .pop_i   (pop),
    .rdata_o (out_item_o),
    .empty_o (empty)
  );

  // checks on the walker
  `AST_NEVER(a_no_push_when_full, out_push && out_full)
  `AST_ASSERT(a_pop_only_at_end,
              cmd_pop_o |-> (state_q == ast_pkg::ST_COMMIT || state_q == ast_pkg::ST_FLUSH))
  `AST_ASSERT(a_work_needs_cmd, (state_q != ast_pkg::ST_IDLE) |-> cmd_valid_i)
  `AST_ASSERT(a_idle_no_pending, (state_q == ast_pkg::ST_IDLE) |-> !pend_v_q)
  `AST_NEVER(a_commit_and_fire, commit_wr && fire_upd)

endmodule

`default_nettype wire

// File: hw/rtl/alarm_slot_table_scheduler.sv
// Alarm slot table: a set request passes through the slot walker's scan and commit states,
// a check request through its scan and flush states and may stall on a full result queue.
// The walker visits one slot a cycle unless a check stalls on a full result queue, and
// takes the next request from the command queue only once back in idle; a two-entry queue on each side.
// A fired id shows the cycle after the next firing slot or the flush. Reset clears active
// flags and both queues.
`default_nettype none

module alarm_slot_table_scheduler #(
  parameter int SLOT_COUNT = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  output logic               full,
  input  wire ast_pkg::in_item_t in_item_i,
  output logic               empty,
  input  wire logic          pop,
  output ast_pkg::out_item_t out_item_o
);

  logic          cmd_valid;
  logic          cmd_pop;
  ast_pkg::cmd_t cmd;

  // request decode and command queue
  ast_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .in_item_i   (in_item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop),
    .cmd_o       (cmd)
  );

  // slot table, walker and result queue
  ast_back #(
    .SlotCount (SLOT_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .out_item_o  (out_item_o)
  );

endmodule

`default_nettype wire
